// ===== sv/ubwa_pkg.sv =====
// Shared types and constants for the unaligned block write assembler.
// No dependencies; used by every module of the block.
`default_nettype none

package ubwa_pkg;

  localparam int TOTAL_BLOCKS = 64;
  localparam int BLOCK_BYTES  = 8;

  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd10;
  localparam logic [3:0] ATTEMPT_SAT      = 4'd15;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_DATA   = 2'd1,
    MODE_STATUS = 2'd2
  } mode_t;

  typedef enum logic {
    KIND_PROGRAM = 1'b0,
    KIND_FINISH  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] start_offset;
    logic [15:0] transfer_length;
    logic        identify_ok;
    logic [7:0]  data_byte;
    logic        program_ok;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  block_address;
    logic [63:0] block_data;
    logic        success;
  } out_item_t;

  // result handed from the control stage to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/ubwa_ctrl.sv =====
// Write sequencer: phase, fill buffer, counters and the attempt register.
// Uses ubwa_pkg. Produces at most one result per accepted item.
`default_nettype none

module ubwa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire ubwa_pkg::in_item_t item,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  output ubwa_pkg::result_t       result
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FILL = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] buffer_r, buffer_nxt;
  logic [2:0]  fill_pos_r, fill_pos_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [5:0]  cur_block_r, cur_block_nxt;
  logic [6:0]  blocks_left_r, blocks_left_nxt;
  logic [3:0]  attempts_r, attempts_nxt;
  logic [3:0]  max_attempts_r;

  logic [12:0] first_blk;
  logic [13:0] blk_count;
  logic [13:0] blk_end;
  logic [15:0] len_m1;
  logic [15:0] bytes_dec;
  logic [6:0]  blocks_dec;
  logic [3:0]  att_inc;
  logic        reject;

  always_comb begin
    first_blk  = item.start_offset[15:3];
    len_m1     = item.transfer_length - 16'd1;
    blk_count  = (item.transfer_length == 16'd0) ? 14'd0 : ({1'b0, len_m1[15:3]} + 14'd1);
    blk_end    = {1'b0, first_blk} + blk_count;
    reject     = !item.identify_ok || (item.transfer_length == 16'd0) ||
                 (blk_end > 14'(ubwa_pkg::TOTAL_BLOCKS));
    bytes_dec  = bytes_left_r - 16'd1;
    blocks_dec = blocks_left_r - 7'd1;
    att_inc    = (attempts_r < ubwa_pkg::ATTEMPT_SAT) ? attempts_r + 4'd1 : attempts_r;
  end

  always_comb begin
    phase_nxt       = phase_r;
    buffer_nxt      = buffer_r;
    fill_pos_nxt    = fill_pos_r;
    bytes_left_nxt  = bytes_left_r;
    cur_block_nxt   = cur_block_r;
    blocks_left_nxt = blocks_left_r;
    attempts_nxt    = attempts_r;
    result          = '0;

    if (accept) begin
      case (ubwa_pkg::mode_t'(item.mode))
        ubwa_pkg::MODE_START: begin
          if (phase_r == PH_IDLE) begin
            if (reject) begin
              result.valid        = 1'b1;
              result.item.kind    = ubwa_pkg::KIND_FINISH;
              result.item.success = 1'b0;
            end else begin
              phase_nxt       = PH_FILL;
              fill_pos_nxt    = ~item.start_offset[2:0];
              bytes_left_nxt  = item.transfer_length;
              cur_block_nxt   = first_blk[5:0];
              blocks_left_nxt = blk_count[6:0];
              attempts_nxt    = '0;
            end
          end
        end
        ubwa_pkg::MODE_DATA: begin
          if (phase_r == PH_FILL) begin
            for (int b = 0; b < ubwa_pkg::BLOCK_BYTES; b++) begin
              if (fill_pos_r == 3'(b)) buffer_nxt[8*b +: 8] = item.data_byte;
            end
            bytes_left_nxt = bytes_dec;
            if (fill_pos_r == 3'd0 || bytes_dec == 16'd0) begin
              phase_nxt                 = PH_WAIT;
              attempts_nxt              = '0;
              result.valid              = 1'b1;
              result.item.kind          = ubwa_pkg::KIND_PROGRAM;
              result.item.block_address = cur_block_r;
              result.item.block_data    = buffer_nxt;
            end else begin
              fill_pos_nxt = fill_pos_r - 3'd1;
            end
          end
        end
        ubwa_pkg::MODE_STATUS: begin
          if (phase_r == PH_WAIT) begin
            attempts_nxt = att_inc;
            if (item.program_ok) begin
              blocks_left_nxt = blocks_dec;
              cur_block_nxt   = cur_block_r + 6'd1;
              attempts_nxt    = '0;
              fill_pos_nxt    = 3'd7;
              if (blocks_dec == 7'd0) begin
                phase_nxt           = PH_IDLE;
                result.valid        = 1'b1;
                result.item.kind    = ubwa_pkg::KIND_FINISH;
                result.item.success = 1'b1;
              end else begin
                phase_nxt = PH_FILL;
              end
            end else if (att_inc >= max_attempts_r) begin
              // out of retries: abandon the whole write
              phase_nxt           = PH_IDLE;
              fill_pos_nxt        = 3'd7;
              blocks_left_nxt     = '0;
              result.valid        = 1'b1;
              result.item.kind    = ubwa_pkg::KIND_FINISH;
              result.item.success = 1'b0;
            end else begin
              result.valid              = 1'b1;
              result.item.kind          = ubwa_pkg::KIND_PROGRAM;
              result.item.block_address = cur_block_r;
              result.item.block_data    = buffer_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      buffer_r       <= '0;
      fill_pos_r     <= 3'd7;
      bytes_left_r   <= '0;
      cur_block_r    <= '0;
      blocks_left_r  <= '0;
      attempts_r     <= '0;
      max_attempts_r <= ubwa_pkg::MAX_ATTEMPTS_RST;
    end else begin
      phase_r       <= phase_nxt;
      buffer_r      <= buffer_nxt;
      fill_pos_r    <= fill_pos_nxt;
      bytes_left_r  <= bytes_left_nxt;
      cur_block_r   <= cur_block_nxt;
      blocks_left_r <= blocks_left_nxt;
      attempts_r    <= attempts_nxt;
      if (cfg_we) max_attempts_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ubwa_out_reg.sv =====
// Result output register with valid/stall handshake.
// Uses ubwa_pkg. Holds one result item until the consumer takes it.
`default_nettype none

module ubwa_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ubwa_pkg::result_t   result,
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ubwa_pkg::out_item_t      out_item
);

  logic                valid_r, valid_nxt;
  ubwa_pkg::out_item_t item_r, item_nxt;
  logic                load;

  // full and stalled: upstream must hold off
  assign busy = valid_r && out_stall;
  assign load = !busy;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = result.valid;
      item_nxt  = result.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

// ===== sv/unaligned_block_write_assembler_unit.sv =====
// A result appears on out_* in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle; in_stall rises only while a result waits under out_stall.
// The single output register sets that figure; all item work happens in the cycle of acceptance.
// Reset (rst_n low, synchronous): phase idle, buffer and counters cleared, fill position 7,
// max_attempts back to 10, no result pending.
`default_nettype none

module unaligned_block_write_assembler_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ubwa_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ubwa_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata
);

  ubwa_pkg::result_t result;
  logic              busy;
  logic              accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  ubwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  ubwa_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== bench/write_assembler_checker.sv =====
// Checker for the unaligned block write assembler: watches the item, result and register ports,
// predicts each result and compares it field by field with what the unit hands out.
// Depends on ubwa_pkg for the item layouts, modes and result kinds.
`timescale 1ns / 1ps

module write_assembler_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire ubwa_pkg::in_item_t  in_item,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire ubwa_pkg::out_item_t out_item,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata,
  output int                       mismatches,
  output int                       outstanding,
  output logic                     filling,
  output logic                     awaiting
);

  typedef enum logic [1:0] {
    WR_IDLE = 2'd0,
    WR_FILL = 2'd1,
    WR_WAIT = 2'd2
  } wr_phase_t;

  wr_phase_t           phase;
  logic [63:0]         block_buf;
  logic [2:0]          fill_pos;
  logic [15:0]         bytes_left;
  logic [5:0]          cur_block;
  logic [6:0]          blocks_left;
  logic [3:0]          attempts;
  logic [3:0]          attempt_limit;
  ubwa_pkg::out_item_t expected_results[$];

  task automatic queue_result(ubwa_pkg::kind_t k, logic [5:0] addr, logic [63:0] data,
                              logic ok);
    ubwa_pkg::out_item_t r;
    r.kind          = k;
    r.block_address = addr;
    r.block_data    = data;
    r.success       = ok;
    expected_results.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < 10)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // one accepted item: update the predicted write state, queue any result it causes
  task automatic assemble_step(ubwa_pkg::in_item_t it);
    int unsigned first;
    int unsigned count;
    case (it.mode)
      ubwa_pkg::MODE_START: begin
        if (phase == WR_IDLE) begin
          first = 32'(it.start_offset) >> 3;
          count = (it.transfer_length == 16'd0) ? 0 :
                  ((int'(it.transfer_length) - 1) >> 3) + 1;
          if (!it.identify_ok || it.transfer_length == 16'd0 ||
              first + count > ubwa_pkg::TOTAL_BLOCKS) begin
            queue_result(ubwa_pkg::KIND_FINISH, '0, '0, 1'b0);
          end else begin
            phase       = WR_FILL;
            fill_pos    = 3'd7 - it.start_offset[2:0];
            bytes_left  = it.transfer_length;
            cur_block   = first[5:0];
            blocks_left = count[6:0];
            attempts    = '0;
          end
        end
      end
      ubwa_pkg::MODE_DATA: begin
        if (phase == WR_FILL) begin
          block_buf[fill_pos*8 +: 8] = it.data_byte;
          bytes_left = bytes_left - 16'd1;
          if (fill_pos == 3'd0 || bytes_left == 16'd0) begin
            phase    = WR_WAIT;
            attempts = '0;
            queue_result(ubwa_pkg::KIND_PROGRAM, cur_block, block_buf, 1'b0);
          end else begin
            fill_pos = fill_pos - 3'd1;
          end
        end
      end
      ubwa_pkg::MODE_STATUS: begin
        if (phase == WR_WAIT) begin
          if (attempts < ubwa_pkg::ATTEMPT_SAT)
            attempts = attempts + 4'd1;
          if (it.program_ok) begin
            blocks_left = blocks_left - 7'd1;
            cur_block   = cur_block + 6'd1;
            attempts    = '0;
            fill_pos    = 3'd7;
            if (blocks_left == 7'd0) begin
              phase = WR_IDLE;
              queue_result(ubwa_pkg::KIND_FINISH, '0, '0, 1'b1);
            end else begin
              phase = WR_FILL;
            end
          end else if (attempts >= attempt_limit) begin
            phase       = WR_IDLE;
            fill_pos    = 3'd7;
            blocks_left = '0;
            queue_result(ubwa_pkg::KIND_FINISH, '0, '0, 1'b0);
          end else begin
            queue_result(ubwa_pkg::KIND_PROGRAM, cur_block, block_buf, 1'b0);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ubwa_pkg::out_item_t want;
    if (!rst_n) begin
      phase         = WR_IDLE;
      block_buf     = '0;
      fill_pos      = 3'd7;
      bytes_left    = '0;
      cur_block     = '0;
      blocks_left   = '0;
      attempts      = '0;
      attempt_limit = ubwa_pkg::MAX_ATTEMPTS_RST;
      mismatches    = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result with nothing pending", '0, out_item.block_data);
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind)
            report("kind", 64'(want.kind), 64'(out_item.kind));
          if (out_item.block_address !== want.block_address)
            report("block_address", 64'(want.block_address), 64'(out_item.block_address));
          if (out_item.block_data !== want.block_data)
            report("block_data", want.block_data, out_item.block_data);
          if (out_item.success !== want.success)
            report("success", 64'(want.success), 64'(out_item.success));
        end
      end
      if (cfg_we)
        attempt_limit = cfg_wdata;
      if (in_valid && !in_stall)
        assemble_step(in_item);
    end
    outstanding = expected_results.size();
    filling     = (phase == WR_FILL);
    awaiting    = (phase == WR_WAIT);
  end

endmodule

// ===== bench/tb.sv =====
// Top of the write assembler bench: clock, reset, item and register stimulus, verdict.
// Depends on ubwa_pkg, unaligned_block_write_assembler_unit and write_assembler_checker.
`timescale 1ns / 1ps

module tb;

  localparam int         CYCLE_LIMIT = 500000;
  localparam int         PHASE_ITEMS = 255;
  // mode code with no meaning; the unit must ignore it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  ubwa_pkg::in_item_t  in_item = '0;
  logic                out_stall = 1'b0;
  logic                cfg_we = 1'b0;
  logic [3:0]          cfg_wdata = '0;
  logic                in_stall;
  logic                out_valid;
  ubwa_pkg::out_item_t out_item;
  int                  mismatches;
  int                  outstanding;
  logic                filling;
  logic                awaiting;

  int          cycles = 0;
  int          sent = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b0;
  bit          quiet = 1'b0;
  logic [3:0]  attempt_limit = ubwa_pkg::MAX_ATTEMPTS_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  unaligned_block_write_assembler_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  write_assembler_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .filling     (filling),
    .awaiting    (awaiting)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(7, 0) == 0)
        stall_left = $urandom_range(14, 1);
      out_stall <= (stall_left != 0);
      if (stall_left != 0)
        stall_left--;
    end
  end

  function automatic ubwa_pkg::in_item_t start_item(logic [15:0] off, logic [15:0] len,
                                                    logic id_ok);
    ubwa_pkg::in_item_t it;
    it = '0;
    it.mode            = ubwa_pkg::MODE_START;
    it.start_offset    = off;
    it.transfer_length = len;
    it.identify_ok     = id_ok;
    return it;
  endfunction

  function automatic ubwa_pkg::in_item_t data_item(logic [7:0] b);
    ubwa_pkg::in_item_t it;
    it = '0;
    it.mode      = ubwa_pkg::MODE_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic ubwa_pkg::in_item_t status_item(logic ok);
    ubwa_pkg::in_item_t it;
    it = '0;
    it.mode       = ubwa_pkg::MODE_STATUS;
    it.program_ok = ok;
    return it;
  endfunction

  function automatic ubwa_pkg::in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(ubwa_pkg::in_item_t)-1:0];
  endfunction

  // valid stays high from one item to the next unless a gap is taken
  task automatic send(ubwa_pkg::in_item_t it);
    if (idle_on && $urandom_range(5, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // hold off until every result is in, finishing any write left half done
  task automatic settle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (outstanding == 0 && !filling && !awaiting)
        break;
      if (outstanding == 0) begin
        @(posedge clk);
        in_valid <= 1'b1;
        in_item  <= filling ? data_item(8'($urandom_range(255, 0))) : status_item(1'b1);
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
      end
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_attempt_limit(logic [3:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    attempt_limit = v;
  endtask

  // items the unit must ignore in the current phase of a write
  task automatic maybe_stray(bit mid_fill);
    ubwa_pkg::in_item_t it;
    if ($urandom_range(24, 0) == 0) begin
      case ($urandom_range(2, 0))
        0: it = start_item(16'($urandom_range(255, 0)), 16'($urandom_range(64, 1)), 1'b1);
        1: it = mid_fill ? status_item(1'($urandom_range(1, 0)))
                         : data_item(8'($urandom_range(255, 0)));
        default: begin
          it = noise_item();
          it.mode = MODE_UNUSED;
        end
      endcase
      send(it);
      sent--;
    end
  endtask

  task automatic write_sequence();
    int  first;
    int  skip;
    int  room;
    int  len;
    int  count;
    int  left;
    int  take;
    int  fill;
    int  tries;
    int  eff;
    int  pick;
    bit  id_ok;
    bit  doomed;
    bit  ok;
    idle_on = !quiet && $urandom_range(4, 0) != 0;
    first = $urandom_range(63, 0);
    skip  = $urandom_range(7, 0);
    room  = (64 - first) * 8;
    pick  = $urandom_range(99, 0);
    id_ok = (pick >= 4);
    if ($urandom_range(9, 0) == 0)
      len = $urandom_range(room, 1);
    else
      len = $urandom_range((room < 20) ? room : 20, 1);
    if (pick >= 4 && pick < 8)
      len = room + $urandom_range(16, 1);
    else if (pick >= 8 && pick < 10)
      len = 0;
    send(start_item(16'(first * 8 + skip), 16'(len), id_ok));
    count = (len + 7) / 8;
    if (!id_ok || len == 0 || first + count > ubwa_pkg::TOTAL_BLOCKS)
      return;
    eff    = (attempt_limit == 4'd0) ? 1 : int'(attempt_limit);
    doomed = ($urandom_range(11, 0) == 0);
    left   = len;
    fill   = 7 - skip;
    for (int b = 0; b < count; b++) begin
      take = (left < fill + 1) ? left : fill + 1;
      repeat (take) begin
        maybe_stray(1'b1);
        send(data_item(8'($urandom_range(255, 0))));
      end
      left -= take;
      fill  = 7;
      tries = 0;
      do begin
        maybe_stray(1'b0);
        ok = !doomed && $urandom_range(3, 0) != 0;
        send(status_item(ok));
        tries++;
      end while (!ok && tries < eff);
      if (!ok)
        return;
    end
    // bytes past the last block are dropped by the unit
    if (left > 0 && $urandom_range(1, 0) == 0)
      repeat ((left > 3) ? 3 : left) send(data_item(8'($urandom_range(255, 0))));
  endtask

  // random items, sometimes after a write has been opened, then a drain
  task automatic noise_burst();
    idle_on = !quiet && $urandom_range(1, 0) != 0;
    if ($urandom_range(1, 0) == 0)
      send(start_item(16'($urandom_range(300, 0)), 16'($urandom_range(40, 1)), 1'b1));
    repeat ($urandom_range(10, 3)) send(noise_item());
    settle();
  endtask

  initial begin
    logic [3:0]         limits[6];
    ubwa_pkg::in_item_t odd;
    limits = '{4'd1, 4'd15, 4'd0, 4'd10, 4'd3, 4'd15};
    limits[4] = 4'($urandom_range(14, 2));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejections, ignored items, a retry, offset and surplus handling
    send(start_item(16'd0, 16'd8, 1'b0));
    send(start_item(16'd0, 16'd0, 1'b1));
    send(start_item(16'hFFFF, 16'hFFFF, 1'b1));
    send(start_item(16'd504, 16'd9, 1'b1));
    send(data_item(8'hA5));
    send(status_item(1'b1));
    odd = '1;
    send(odd);
    send(start_item(16'd511, 16'd1, 1'b1));
    send(start_item(16'd0, 16'd8, 1'b1));
    send(status_item(1'b0));
    send(data_item(8'hFF));
    send(data_item(8'h00));
    send(status_item(1'b0));
    send(status_item(1'b1));
    send(start_item(16'd5, 16'd4, 1'b1));
    send(data_item(8'h00));
    send(data_item(8'h80));
    send(data_item(8'h7F));
    send(status_item(1'b1));
    send(data_item(8'h11));
    settle();

    foreach (limits[p]) begin
      if (p == 5) begin
        quiet   = 1'b1;
        idle_on = 1'b0;
      end
      set_attempt_limit(limits[p]);
      while (sent < 20 + (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99, 0) < 88)
          write_sequence();
        else if (!quiet)
          noise_burst();
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== unaligned_block_write_assembler_unit.f =====
sv/ubwa_pkg.sv
sv/ubwa_ctrl.sv
sv/ubwa_out_reg.sv
sv/unaligned_block_write_assembler_unit.sv
bench/write_assembler_checker.sv
bench/tb.sv
